// ===== rtl/core/mcpf_pkg.sv =====
`default_nettype none

package mcpf_pkg;

   // default sizing
   localparam int NUM_PIPES_DEF = 8;
   localparam int BUF_DEPTH_DEF = 4096;

   // request codes
   localparam logic [2:0] REQ_ALLOC    = 3'd0;
   localparam logic [2:0] REQ_SET_RD   = 3'd1;
   localparam logic [2:0] REQ_SET_WR   = 3'd2;
   localparam logic [2:0] REQ_CLOSE_RD = 3'd3;
   localparam logic [2:0] REQ_CLOSE_WR = 3'd4;
   localparam logic [2:0] REQ_WRITE    = 3'd5;
   localparam logic [2:0] REQ_READ     = 3'd6;

   // status codes
   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_ERR    = 3'd1;
   localparam logic [2:0] ST_BLOCK  = 3'd2;
   localparam logic [2:0] ST_FULL   = 3'd3;
   localparam logic [2:0] ST_NOFREE = 3'd4;

   typedef logic [2:0] code_type;
   typedef logic [7:0] byte_type;

endpackage

`default_nettype wire

// ===== rtl/core/mcpf_if.sv =====
`default_nettype none

// request channel: one word per pipe request
interface mcpf_req_if;
   logic                valid;
   logic                ready;
   mcpf_pkg::code_type  req_type;
   logic [2:0]          pipe_index;
   mcpf_pkg::byte_type  task_id;
   mcpf_pkg::byte_type  data_byte;
   logic                write_last;

   modport source (output valid, req_type, pipe_index, task_id, data_byte, write_last,
                   input ready);
   modport sink   (input valid, req_type, pipe_index, task_id, data_byte, write_last,
                   output ready);
endinterface

// response channel: one word per request
interface mcpf_rsp_if;
   logic                valid;
   logic                ready;
   mcpf_pkg::code_type  status;
   logic [2:0]          alloc_index;
   mcpf_pkg::byte_type  read_byte;

   modport source (output valid, status, alloc_index, read_byte, input ready);
   modport sink   (input valid, status, alloc_index, read_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/multi_channel_pipe_fifo_core.sv =====
// Multi-channel pipe FIFO core.
// A fixed set of byte pipes, each a ring buffer of BUF_DEPTH slots in one
// shared byte memory (one slot per pipe always stays empty).
// req_ch carries one request word: alloc, set/close reader or writer,
// write byte or read byte. rsp_ch returns exactly one response word per
// request, in order: status, granted pipe for alloc, popped byte for read.
// A response is registered at the edge that accepts its request and is
// valid in the cycle after it. One request per cycle while the response
// slot is not stalled; pointer and endpoint state sits in flops and is
// updated at the accepting edge, the byte memory is written or read at
// that same edge and its read register drives the response byte directly.
// req_ch.ready is high while the response slot is empty or being taken, so
// a stalled receiver holds the response and stops intake after one word.
// Reset (synchronous, active high) frees all pipes and empties the response
// slot; byte memory contents are not cleared and need no clearing pass.
`default_nettype none

module multi_channel_pipe_fifo_core #(
   parameter int NUM_PIPES = mcpf_pkg::NUM_PIPES_DEF,
   parameter int BUF_DEPTH = mcpf_pkg::BUF_DEPTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   mcpf_req_if.sink   req_ch,
   mcpf_rsp_if.source rsp_ch
);
   import mcpf_pkg::*;

   localparam int PIPE_W = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
   localparam int PTR_W  = $clog2(BUF_DEPTH);
   localparam int MEM_SZ = NUM_PIPES * BUF_DEPTH;
   localparam int ADDR_W = $clog2(MEM_SZ);

   // per-pipe control state
   logic [NUM_PIPES-1:0] in_use_ff;
   logic [NUM_PIPES-1:0] rd_present_ff;
   logic [NUM_PIPES-1:0] wr_present_ff;
   logic [PTR_W-1:0]     head_ff [NUM_PIPES];
   logic [PTR_W-1:0]     tail_ff [NUM_PIPES];
   byte_type             rd_task_ff [NUM_PIPES];
   byte_type             wr_task_ff [NUM_PIPES];

   // byte store
   byte_type             mem [MEM_SZ];
   byte_type             mem_q_ff;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   code_type             status_ff;
   logic [2:0]           aidx_ff;
   logic                 rd_sel_ff;

   logic                 req_fire;
   logic [PIPE_W-1:0]    pidx;
   logic                 idx_ok;
   logic [PTR_W-1:0]     cur_head, cur_tail, head_next, tail_next;
   logic                 cur_rd, cur_wr;
   logic                 free_found;
   logic [PIPE_W-1:0]    free_idx;
   logic [ADDR_W-1:0]    mem_addr;

   code_type             status_c;
   logic [2:0]           aidx_c;
   logic                 alloc_go, set_rd, set_wr, clr_rd, clr_wr;
   logic                 do_write, do_read, release_go;

   // handshake
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;

   // addressed pipe lookup
   assign pidx      = PIPE_W'(req_ch.pipe_index);
   assign idx_ok    = (32'(req_ch.pipe_index) < 32'(NUM_PIPES)) && in_use_ff[pidx];
   assign cur_head  = head_ff[pidx];
   assign cur_tail  = tail_ff[pidx];
   assign cur_rd    = rd_present_ff[pidx];
   assign cur_wr    = wr_present_ff[pidx];
   assign head_next = (32'(cur_head) == 32'(BUF_DEPTH - 1)) ? '0 : cur_head + 1'b1;
   assign tail_next = (32'(cur_tail) == 32'(BUF_DEPTH - 1)) ? '0 : cur_tail + 1'b1;

   // lowest free pipe
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_PIPES - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_found = 1'b1;
            free_idx   = PIPE_W'(i);
         end
      end
   end

   // request decode
   always_comb begin
      status_c = ST_ERR;
      aidx_c   = '0;
      alloc_go = 1'b0;
      set_rd   = 1'b0;
      set_wr   = 1'b0;
      clr_rd   = 1'b0;
      clr_wr   = 1'b0;
      do_write = 1'b0;
      do_read  = 1'b0;
      case (req_ch.req_type)
         REQ_ALLOC: begin
            if (free_found) begin
               alloc_go = 1'b1;
               status_c = ST_OK;
               aidx_c   = 3'(free_idx);
            end else begin
               status_c = ST_NOFREE;
            end
         end
         REQ_SET_RD: begin
            if (idx_ok) begin
               set_rd   = 1'b1;
               status_c = ST_OK;
            end
         end
         REQ_SET_WR: begin
            if (idx_ok) begin
               set_wr   = 1'b1;
               status_c = ST_OK;
            end
         end
         REQ_CLOSE_RD: begin
            if (idx_ok) begin
               clr_rd   = 1'b1;
               status_c = ST_OK;
            end
         end
         REQ_CLOSE_WR: begin
            if (idx_ok) begin
               clr_wr   = 1'b1;
               status_c = ST_OK;
            end
         end
         REQ_WRITE: begin
            if (idx_ok && cur_rd) begin
               if (head_next == cur_tail) begin
                  status_c = ST_FULL;
               end else begin
                  do_write = 1'b1;
                  status_c = ST_OK;
               end
            end
         end
         REQ_READ: begin
            if (idx_ok) begin
               if (cur_head == cur_tail) begin
                  status_c = cur_wr ? ST_BLOCK : ST_ERR;
               end else begin
                  do_read  = 1'b1;
                  status_c = ST_OK;
               end
            end
         end
         default: begin
            status_c = ST_ERR;
         end
      endcase
   end

   // pipe freed once both endpoints are gone
   assign release_go = (clr_rd && !cur_wr) || (clr_wr && !cur_rd);

   // control state update
   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff     <= '0;
         rd_present_ff <= '0;
         wr_present_ff <= '0;
         for (int i = 0; i < NUM_PIPES; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
         end
      end else if (req_fire) begin
         if (alloc_go) begin
            in_use_ff[free_idx]     <= 1'b1;
            rd_present_ff[free_idx] <= 1'b0;
            wr_present_ff[free_idx] <= 1'b0;
            head_ff[free_idx]       <= '0;
            tail_ff[free_idx]       <= '0;
         end
         if (set_rd) begin
            rd_present_ff[pidx] <= 1'b1;
         end
         if (set_wr) begin
            wr_present_ff[pidx] <= 1'b1;
         end
         if (clr_rd) begin
            rd_present_ff[pidx] <= 1'b0;
         end
         if (clr_wr) begin
            wr_present_ff[pidx] <= 1'b0;
         end
         if (release_go) begin
            in_use_ff[pidx] <= 1'b0;
         end
         if (do_write) begin
            head_ff[pidx] <= head_next;
         end
         if (do_read) begin
            tail_ff[pidx] <= tail_next;
         end
      end
   end

   // endpoint task ids
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PIPES; i++) begin
            rd_task_ff[i] <= '0;
            wr_task_ff[i] <= '0;
         end
      end else begin
         if (req_fire && alloc_go) begin
            rd_task_ff[free_idx] <= '0;
            wr_task_ff[free_idx] <= '0;
         end
         if (req_fire && set_rd) begin
            rd_task_ff[pidx] <= req_ch.task_id;
         end
         if (req_fire && set_wr) begin
            wr_task_ff[pidx] <= req_ch.task_id;
         end
      end
   end

   // byte memory: pipe base plus head (write) or tail (read)
   assign mem_addr = ADDR_W'(pidx) * ADDR_W'(BUF_DEPTH) +
                     ADDR_W'(do_write ? cur_head : cur_tail);

   always_ff @(posedge clock) begin
      if (req_fire && do_write) begin
         mem[mem_addr] <= req_ch.data_byte;
      end
      if (req_fire && do_read) begin
         mem_q_ff <= mem[mem_addr];
      end
   end

   // response slot
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         status_ff <= status_c;
         aidx_ff   <= aidx_c;
         rd_sel_ff <= do_read;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.alloc_index = aidx_ff;
   assign rsp_ch.read_byte   = rd_sel_ff ? mem_q_ff : '0;

   // every accepted request leaves a response in the slot
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   // no intake while a response is held back
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |-> !req_fire)
      else $error("request accepted over a stalled response");

   // granted pipe is marked in use after alloc
   a_alloc_marks: assert property (@(posedge clock) disable iff (reset)
      (req_fire && alloc_go) |=> in_use_ff[$past(free_idx)])
      else $error("allocated pipe not marked in use");

   // ring pointers stay inside the buffer
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (32'(cur_head) < 32'(BUF_DEPTH)) && (32'(cur_tail) < 32'(BUF_DEPTH)))
      else $error("ring pointer out of range");

endmodule

`default_nettype wire
